// ===== hdl/frnd_pkg.sv =====
// Shared types, constants and functions for the rounding and integer conversion unit.
package frnd_pkg;

	typedef enum logic [2:0] {
		CMD_ROUND   = 3'd0,
		CMD_TRUNC   = 3'd1,
		CMD_D_TO_32 = 3'd2,
		CMD_D_TO_16 = 3'd3,
		CMD_S_TO_32 = 3'd4,
		CMD_S_TO_16 = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [63:0] value_bits;
	} in_item_t;

	typedef struct packed {
		logic [63:0]        float_result;
		logic signed [31:0] int_result;
		logic               status;
	} out_item_t;

	localparam logic [10:0] EXP_ALL1  = 11'h7ff;
	localparam logic [10:0] EXP_BIAS  = 11'h3ff;
	localparam logic [63:0] QUIET_BIT = 64'h0008_0000_0000_0000;
	localparam logic [63:0] ONE_BITS  = 64'h3ff0_0000_0000_0000;
	localparam logic [31:0] I32_POS   = 32'd2147483647;
	localparam logic [31:0] I32_NEG   = 32'd2147483648;
	localparam logic [31:0] I16_POS   = 32'd32767;
	localparam logic [31:0] I16_NEG   = 32'd32768;

	// Single to double; exact, subnormals normalized by a priority search.
	function automatic logic [63:0] s_to_d(input logic [31:0] f);
		logic [7:0]  e;
		logic [22:0] m;
		logic [22:0] mn;
		logic [10:0] de;
		int          lz;
		begin
			e  = f[30:23];
			m  = f[22:0];
			lz = 0;
			for (int i = 0; i < 23; i++)
				if (m[i])
					lz = 22 - i;
			mn = 23'(m << (lz + 1));
			de = 11'(1023 - 127 - lz);
			if (e == 8'hff)
				s_to_d = {f[31], EXP_ALL1, m, 29'd0};
			else if (e == 8'd0 && m == 23'd0)
				s_to_d = {f[31], 63'd0};
			else if (e == 8'd0)
				s_to_d = {f[31], de, mn, 29'd0};
			else
				s_to_d = {f[31], 11'({3'd0, e} + 11'd896), m, 29'd0};
		end
	endfunction

	function automatic logic [63:0] round_even(input logic [63:0] b);
		logic [10:0] e;
		logic [63:0] mask, half, frac, base, odd, one_fb;
		logic [5:0]  fb;
		begin
			e      = b[62:52];
			fb     = 6'(11'd1075 - e);
			one_fb = 64'd1 << fb;
			mask   = one_fb - 64'd1;
			half   = one_fb >> 1;
			frac   = b & mask;
			base   = b & ~mask;
			odd    = (e == EXP_BIAS) ? 64'd1 : ((b >> fb) & 64'd1);
			if (e == EXP_ALL1)
				round_even = (b[51:0] != 52'd0) ? (b | QUIET_BIT) : b;
			else if (e >= 11'd1075)
				round_even = b;
			else if (e < EXP_BIAS)
				round_even = (e == 11'd1022 && b[51:0] != 52'd0) ?
					({b[63], 63'd0} | ONE_BITS) : {b[63], 63'd0};
			else if (frac == 64'd0)
				round_even = b;
			else if (frac > half || (frac == half && odd[0]))
				round_even = base + one_fb;
			else
				round_even = base;
		end
	endfunction

	function automatic logic [63:0] trunc_zero(input logic [63:0] b);
		logic [10:0] e;
		logic [5:0]  fb;
		begin
			e  = b[62:52];
			fb = 6'(11'd1075 - e);
			if (e == EXP_ALL1)
				trunc_zero = (b[51:0] != 52'd0) ? (b | QUIET_BIT) : b;
			else if (e >= 11'd1075)
				trunc_zero = b;
			else if (e < EXP_BIAS)
				trunc_zero = {b[63], 63'd0};
			else
				trunc_zero = b & ~((64'd1 << fb) - 64'd1);
		end
	endfunction

endpackage

// ===== hdl/float_round_and_int_convert.sv =====
// Top level of the rounding and integer conversion unit.
// Usage: drive in (cmd, value_bits) with in_valid; a transfer happens when
// in_valid and in_ready are both high. Each transfer yields one result on
// out (float_result, int_result, status) under out_valid/out_ready.
// cmd 0 rounds a double to nearest, ties to even; cmd 1 truncates; cmd 2..5 convert
// a double or a single to int32/int16, status flags range, NaN or inf; cmd 6..7 give zero.
// An item passes the input register, then the result register.
// Throughput: one item per cycle while the receiver takes results; the
// conversion logic between the two registers is the only work.
// A stalled receiver holds the result register; the input stage still
// takes one more item while the result register waits, then in_ready drops.
// Reset clears both valid flags; the data registers are not reset.
module float_round_and_int_convert (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  frnd_pkg::in_item_t   in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output frnd_pkg::out_item_t  out
);

	logic                v_s1;
	frnd_pkg::in_item_t  d_s1;
	logic                adv;
	frnd_pkg::out_item_t res;

	logic [63:0] dv, r;
	logic [10:0] e, re;
	logic [5:0]  fb, rfb;
	logic [52:0] mant;
	logic [63:0] ip;
	logic        frac, neg, wide, bad;
	logic [31:0] lim, mag;

	assign adv      = !out_valid || out_ready;
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (in_ready)
				v_s1 <= in_valid;
			if (adv)
				out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			d_s1 <= in;
		if (adv && v_s1)
			out <= res;
	end

	always_comb begin
		wide = (d_s1.cmd == frnd_pkg::CMD_D_TO_32) || (d_s1.cmd == frnd_pkg::CMD_S_TO_32);
		dv   = (d_s1.cmd == frnd_pkg::CMD_S_TO_32 || d_s1.cmd == frnd_pkg::CMD_S_TO_16) ?
			frnd_pkg::s_to_d(d_s1.value_bits[31:0]) : d_s1.value_bits;
		neg  = dv[63];
		e    = dv[62:52];
		fb   = 6'(11'd1075 - e);
		mant = {1'b1, dv[51:0]};
		ip   = 64'(mant) >> fb;
		frac = ((64'(mant) & ((64'd1 << fb) - 64'd1)) != 64'd0);
		if (e < frnd_pkg::EXP_BIAS) begin
			ip   = 64'd0;
			frac = (dv[62:0] != 63'd0);
		end
		lim = wide ? (neg ? frnd_pkg::I32_NEG : frnd_pkg::I32_POS) :
			(neg ? frnd_pkg::I16_NEG : frnd_pkg::I16_POS);
		bad = (e == frnd_pkg::EXP_ALL1) || (e >= 11'd1055) ||
			(ip > 64'(lim)) || (ip == 64'(lim) && frac);
		r   = frnd_pkg::round_even(dv);
		re  = r[62:52];
		rfb = 6'(11'd1075 - re);
		mag = (re < frnd_pkg::EXP_BIAS) ? 32'd0 : 32'(64'({1'b1, r[51:0]}) >> rfb);
		res = '0;
		unique case (d_s1.cmd)
			frnd_pkg::CMD_ROUND: res.float_result = frnd_pkg::round_even(d_s1.value_bits);
			frnd_pkg::CMD_TRUNC: res.float_result = frnd_pkg::trunc_zero(d_s1.value_bits);
			frnd_pkg::CMD_D_TO_32, frnd_pkg::CMD_D_TO_16,
			frnd_pkg::CMD_S_TO_32, frnd_pkg::CMD_S_TO_16: begin
				res.status     = bad;
				res.int_result = bad ? 32'sd0 : (neg ? $signed(32'd0 - mag) : $signed(mag));
			end
			default: res = '0;
		endcase
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out))
		else $error("result changed while stalled");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item lost");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s1 && out_valid)
		else $error("input stalled with room");
	a_err0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out.status |-> out.int_result == 32'sd0 && out.float_result == 64'd0)
		else $error("error result not zero");

endmodule

// ===== test/tb_float_round_and_int_convert.sv =====
// Testbench for the rounding and integer conversion unit: directed table plus random traffic.
`timescale 1ns / 100ps

module tb_float_round_and_int_convert;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	frnd_pkg::in_item_t   in;
	logic                 out_valid;
	logic                 out_ready;
	frnd_pkg::out_item_t  out;

	float_round_and_int_convert DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in(in),
		.out_valid(out_valid), .out_ready(out_ready), .out(out)
	);

	frnd_pkg::out_item_t pending_results[$];
	int        errors;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        hold_off;

	typedef struct {
		frnd_pkg::cmd_t      cmd;
		logic [63:0]         value;
		logic                known;
		frnd_pkg::out_item_t result;
	} row_t;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Single to double, exact.
	function automatic logic [63:0] widen_single(input logic [31:0] f);
		logic [10:0] e;
		logic [22:0] m;
		begin
			e = {3'd0, f[30:23]};
			m = f[22:0];
			if (f[30:23] == 8'hff)
				return {f[31], 11'h7ff, m, 29'd0};
			if (f[30:23] == 8'd0) begin
				if (m == 23'd0)
					return {f[31], 63'd0};
				e = 11'd897;
				while (!m[22]) begin
					m = m << 1;
					e = e - 11'd1;
				end
				m = m << 1;
				return {f[31], e - 11'd1, m, 29'd0};
			end
			return {f[31], e + 11'd896, m, 29'd0};
		end
	endfunction

	function automatic logic [63:0] nearest_even(input logic [63:0] b);
		int          j;
		logic [63:0] mask, frac, half, base;
		logic        odd;
		begin
			j = int'(b[62:52]) - 1023;
			if (b[62:52] == 11'h7ff)
				return (b[51:0] != 0) ? (b | 64'h0008_0000_0000_0000) : b;
			if (j >= 52)
				return b;
			if (j < 0)
				return (j == -1 && b[51:0] != 0) ? {b[63], 63'h3ff0_0000_0000_0000}
					: {b[63], 63'd0};
			mask = (64'd1 << (52 - j)) - 1;
			frac = b & mask;
			half = 64'd1 << (51 - j);
			base = b & ~mask;
			odd  = (j == 0) ? 1'b1 : b[52 - j];
			if (frac == 0)
				return b;
			if (frac > half || (frac == half && odd))
				base = base + (64'd1 << (52 - j));
			return base;
		end
	endfunction

	function automatic logic [63:0] chop_to_zero(input logic [63:0] b);
		int j;
		begin
			j = int'(b[62:52]) - 1023;
			if (b[62:52] == 11'h7ff)
				return (b[51:0] != 0) ? (b | 64'h0008_0000_0000_0000) : b;
			if (j >= 52)
				return b;
			if (j < 0)
				return {b[63], 63'd0};
			return b & ~((64'd1 << (52 - j)) - 1);
		end
	endfunction

	// Returns 1 on range error or NaN/inf.
	function automatic logic to_integer(input logic [63:0] b, input logic narrow,
			output logic [31:0] res);
		int          j;
		logic [63:0] lim, ip, mant, r, mag;
		logic        frac;
		begin
			res = 0;
			j = int'(b[62:52]) - 1023;
			lim = narrow ? (b[63] ? 64'd32768 : 64'd32767)
				: (b[63] ? 64'd2147483648 : 64'd2147483647);
			if (b[62:52] == 11'h7ff || j >= 32)
				return 1'b1;
			if (j < 0) begin
				ip = 0;
				frac = b[62:0] != 0;
			end else begin
				mant = {11'd0, 1'b1, b[51:0]};
				ip = mant >> (52 - j);
				frac = (mant & ((64'd1 << (52 - j)) - 1)) != 0;
			end
			if (ip > lim || (ip == lim && frac))
				return 1'b1;
			r = nearest_even(b);
			j = int'(r[62:52]) - 1023;
			mag = (j < 0) ? 64'd0 : ({11'd0, 1'b1, r[51:0]} >> (52 - j));
			res = b[63] ? (32'd0 - mag[31:0]) : mag[31:0];
			return 1'b0;
		end
	endfunction

	function automatic frnd_pkg::out_item_t convert_item(input frnd_pkg::in_item_t it);
		frnd_pkg::out_item_t o;
		logic [31:0]         r;
		logic [63:0]         v;
		begin
			o = '0;
			r = 0;
			v = it.cmd[2] ? widen_single(it.value_bits[31:0]) : it.value_bits;
			case (it.cmd)
				frnd_pkg::CMD_ROUND: o.float_result = nearest_even(it.value_bits);
				frnd_pkg::CMD_TRUNC: o.float_result = chop_to_zero(it.value_bits);
				frnd_pkg::CMD_D_TO_32, frnd_pkg::CMD_S_TO_32:
					o.status = to_integer(v, 1'b0, r);
				frnd_pkg::CMD_D_TO_16, frnd_pkg::CMD_S_TO_16:
					o.status = to_integer(v, 1'b1, r);
				default: ;
			endcase
			o.int_result = o.status ? 32'sd0 : signed'(r);
			return o;
		end
	endfunction

	task automatic send_item(input logic [2:0] cmd, input logic [63:0] value, input logic known,
			input frnd_pkg::out_item_t result);
		frnd_pkg::in_item_t it;
		begin
			while ($urandom_range(99) < send_idle_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			it.cmd = cmd;
			it.value_bits = value;
			in_valid <= 1'b1;
			in <= it;
			pending_results.push_back(known ? result : convert_item(it));
			do @(posedge clk); while (!in_ready);
		end
	endtask

	// Check on the edge at which a result transfers.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, out);
				errors++;
			end else begin
				frnd_pkg::out_item_t want;
				want = pending_results.pop_front();
				if (want.float_result !== out.float_result || want.int_result !== out.int_result
						|| want.status !== out.status) begin
					$display("%0t: expected %h %h %b, actual %h %h %b", $time,
						want.float_result, want.int_result, want.status,
						out.float_result, out.int_result, out.status);
					errors++;
				end
			end
		end
	end

	// Receiver: random stall, plus one long hold-off when requested.
	always @(posedge clk) begin
		if (hold_off > 0) begin
			out_ready <= 1'b0;
			hold_off <= hold_off - 1;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic [63:0] random_value(input logic [2:0] cmd);
		logic [63:0] v;
		begin
			v = {$urandom, $urandom};
			case ($urandom_range(5))
				0: ;
				1: v[62:52] = 11'd1000 + 11'($urandom_range(60));
				2: v[62:52] = 11'd1021 + 11'($urandom_range(35));
				3: v[62:52] = $urandom_range(1) ? 11'h7ff : 11'd0;
				4: v[51:0] = v[51:0] & (52'hf_ffff_ffff_ffff << $urandom_range(52));
				default: v = {$urandom, 1'b0, 8'd110 + 8'($urandom_range(50)), 23'($urandom)};
			endcase
			if (cmd < 4 && $urandom_range(3) == 0)
				v[62:52] = 11'd1023 + 11'($urandom_range(33));
			return v;
		end
	endfunction

	row_t table_rows[$];

	task automatic add_row(input frnd_pkg::cmd_t c, input logic [63:0] v, input logic known,
			input logic [63:0] f, input logic [31:0] i, input logic s);
		row_t r;
		begin
			r.cmd = c;
			r.value = v;
			r.known = known;
			r.result = {f, i, s};
			table_rows.push_back(r);
		end
	endtask

	initial begin
		clk = 1'b0;
		errors = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in = '0;
		out_ready = 1'b0;
		hold_off = 0;
		send_idle_pct = 18;
		recv_idle_pct = 77;
		add_row(frnd_pkg::CMD_ROUND, 64'h3fe0_0000_0000_0000, 1, 64'h0, 0, 0);
		add_row(frnd_pkg::CMD_ROUND, 64'hbfe8_0000_0000_0000, 1, 64'hbff0_0000_0000_0000, 0, 0);
		add_row(frnd_pkg::CMD_ROUND, 64'h3ff8_0000_0000_0000, 1, 64'h4000_0000_0000_0000, 0, 0);
		add_row(frnd_pkg::CMD_ROUND, 64'h4004_0000_0000_0000, 1, 64'h4000_0000_0000_0000, 0, 0);
		add_row(frnd_pkg::CMD_ROUND, 64'h7ff0_0000_0000_0001, 1, 64'h7ff8_0000_0000_0001, 0, 0);
		add_row(frnd_pkg::CMD_ROUND, 64'hfff0_0000_0000_0000, 1, 64'hfff0_0000_0000_0000, 0, 0);
		add_row(frnd_pkg::CMD_ROUND, 64'h8000_0000_0000_0001, 1, 64'h8000_0000_0000_0000, 0, 0);
		add_row(frnd_pkg::CMD_ROUND, 64'hffff_ffff_ffff_ffff, 0, 0, 0, 0);
		add_row(frnd_pkg::CMD_TRUNC, 64'hbfef_ffff_ffff_ffff, 1, 64'h8000_0000_0000_0000, 0, 0);
		add_row(frnd_pkg::CMD_TRUNC, 64'h7ff4_0000_0000_0000, 1, 64'h7ffc_0000_0000_0000, 0, 0);
		add_row(frnd_pkg::CMD_TRUNC, 64'h400c_cccc_cccc_cccd, 0, 0, 0, 0);
		add_row(frnd_pkg::CMD_D_TO_32, 64'h41df_ffff_ffc0_0000, 1, 0, 32'h7fff_ffff, 0);
		add_row(frnd_pkg::CMD_D_TO_32, 64'h41df_ffff_fff0_0000, 1, 0, 0, 1);
		add_row(frnd_pkg::CMD_D_TO_32, 64'hc1e0_0000_0000_0000, 1, 0, 32'h8000_0000, 0);
		add_row(frnd_pkg::CMD_D_TO_32, 64'h7ff8_0000_0000_0000, 1, 0, 0, 1);
		add_row(frnd_pkg::CMD_D_TO_32, 64'hfff0_0000_0000_0000, 1, 0, 0, 1);
		add_row(frnd_pkg::CMD_D_TO_16, 64'h40df_ffc0_0000_0000, 1, 0, 32'd32767, 0);
		add_row(frnd_pkg::CMD_D_TO_16, 64'hc0e0_0000_0000_0000, 1, 0, 32'hffff_8000, 0);
		add_row(frnd_pkg::CMD_D_TO_16, 64'hc0e0_0000_1000_0000, 1, 0, 0, 1);
		add_row(frnd_pkg::CMD_S_TO_32, 64'hffff_ffff_4f00_0000, 1, 0, 0, 1);
		add_row(frnd_pkg::CMD_S_TO_32, 64'h0000_0000_8000_0001, 1, 0, 0, 0);
		add_row(frnd_pkg::CMD_S_TO_32, 64'h0000_0000_7fc0_0000, 1, 0, 0, 1);
		add_row(frnd_pkg::CMD_S_TO_16, 64'h0000_0000_c2c5_0000, 0, 0, 0, 0);
		add_row(frnd_pkg::CMD_S_TO_16, 64'h0000_0000_4700_0000, 1, 0, 0, 1);
		add_row(frnd_pkg::cmd_t'(3'd7), 64'h3ff0_0000_0000_0000, 1, 0, 0, 0);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (table_rows[k])
			send_item(table_rows[k].cmd, table_rows[k].value, table_rows[k].known,
				table_rows[k].result);
		for (int n = 0; n < 1450; n++) begin
			logic [2:0] c;
			if (n == 480) begin
				send_idle_pct = 77;
				recv_idle_pct = 18;
			end
			if (n == 960) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
				hold_off <= 60;
			end
			c = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
			send_item(c, random_value(c), 1'b0, '0);
		end
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

endmodule
